/* rtl/rau_pkg.sv */
// rau_pkg: shared types and command codes for the rational arithmetic unit
// no dependencies
package rau_pkg;

  typedef enum logic [2:0] {
    CMD_NORM = 3'd0,
    CMD_ADD  = 3'd1,
    CMD_SUB  = 3'd2,
    CMD_MUL  = 3'd3,
    CMD_DIV  = 3'd4,
    CMD_EQ   = 3'd5,
    CMD_LT   = 3'd6,
    CMD_GT   = 3'd7
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_ZERO = 2'd1,
    ST_OVF  = 2'd2
  } status_t;

  // shared unit operations
  typedef enum logic [3:0] {
    OP_MUL  = 4'd0,   // shift-add multiply, one bit a cycle
    OP_GCD  = 4'd1,   // binary gcd, one step a cycle
    OP_DIV  = 4'd2,   // restoring divide, one bit a cycle
    OP_NONE = 4'd3
  } op_t;

  typedef struct packed {
    logic start;
    op_t  op;
  } unit_req_t;

endpackage

/* rtl/rau_unit.sv */
// rau_unit: shared 64-bit iterative unit (multiply, binary gcd, divide)
// depends on rau_pkg
module rau_unit (
  input  logic              clk,
  input  logic              rst_n,
  input  rau_pkg::unit_req_t req,
  input  logic [63:0]       opa,
  input  logic [63:0]       opb,
  output logic              done,
  output logic [63:0]       res
);

  logic [63:0] x_r, x_nxt, y_r, y_nxt, acc_r, acc_nxt;
  logic [6:0]  cnt_r, cnt_nxt;
  logic [5:0]  sh_r, sh_nxt;
  logic        busy_r, busy_nxt, done_r, done_nxt;
  rau_pkg::op_t op_r, op_nxt;
  logic [64:0] rem_s;
  logic [63:0] dif;

  assign done = done_r;
  assign res  = acc_r;
  assign rem_s = {acc_r, x_r[63]} - {1'b0, y_r};
  assign dif  = (x_r > y_r) ? x_r - y_r : y_r - x_r;

  // one step of the selected operation per cycle
  always_comb begin
    x_nxt = x_r; y_nxt = y_r; acc_nxt = acc_r; cnt_nxt = cnt_r;
    sh_nxt = sh_r; busy_nxt = busy_r; done_nxt = 1'b0; op_nxt = op_r;
    if (req.start) begin
      busy_nxt = 1'b1; op_nxt = req.op; cnt_nxt = 7'd0; sh_nxt = 6'd0;
      x_nxt = opa; y_nxt = opb; acc_nxt = 64'd0;
    end else if (busy_r) begin
      case (op_r)
        rau_pkg::OP_MUL: begin
          if (y_r[0]) acc_nxt = acc_r + x_r;
          x_nxt = {x_r[62:0], 1'b0};
          y_nxt = {1'b0, y_r[63:1]};
          if (y_r[63:1] == 63'd0) begin busy_nxt = 1'b0; done_nxt = 1'b1; end
        end
        rau_pkg::OP_GCD: begin
          if (y_r == 64'd0) begin
            acc_nxt = x_r << sh_r; busy_nxt = 1'b0; done_nxt = 1'b1;
          end else if (x_r == 64'd0) begin
            acc_nxt = y_r << sh_r; busy_nxt = 1'b0; done_nxt = 1'b1;
          end else if (!x_r[0] && !y_r[0]) begin
            x_nxt = x_r >> 1; y_nxt = y_r >> 1; sh_nxt = sh_r + 6'd1;
          end else if (!x_r[0]) begin
            x_nxt = x_r >> 1;
          end else if (!y_r[0]) begin
            y_nxt = y_r >> 1;
          end else begin
            x_nxt = dif >> 1;
            y_nxt = (x_r < y_r) ? x_r : y_r;
          end
        end
        rau_pkg::OP_DIV: begin
          // acc holds the remainder, x shifts quotient bits in
          if (!rem_s[64]) begin
            acc_nxt = rem_s[63:0]; x_nxt = {x_r[62:0], 1'b1};
          end else begin
            acc_nxt = {acc_r[62:0], x_r[63]}; x_nxt = {x_r[62:0], 1'b0};
          end
          cnt_nxt = cnt_r + 7'd1;
          if (cnt_r == 7'd63) begin busy_nxt = 1'b0; done_nxt = 1'b1; end
        end
        default: begin
          busy_nxt = 1'b0; done_nxt = 1'b1;
        end
      endcase
    end
  end

  // the quotient ends in x; move it to the result
  logic [63:0] acc_fin;
  always_comb begin
    acc_fin = acc_nxt;
    if (busy_r && op_r == rau_pkg::OP_DIV && cnt_r == 7'd63) acc_fin = x_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0; done_r <= 1'b0; op_r <= rau_pkg::OP_NONE; cnt_r <= 7'd0;
      sh_r <= 6'd0;
    end else begin
      busy_r <= busy_nxt; done_r <= done_nxt; op_r <= op_nxt; cnt_r <= cnt_nxt;
      sh_r <= sh_nxt;
    end
    x_r <= x_nxt; y_r <= y_nxt; acc_r <= acc_fin;
  end

endmodule

/* rtl/rational_arithmetic_unit.sv */
// rational_arithmetic_unit: top level, sequencer around the shared unit
// depends on rau_pkg and rau_unit
//
// channel  direction  ports
// in       input      in_valid, in_ready, in_command, in_a_num, in_a_den,
//                     in_b_num, in_b_den
// out      output     out_valid, out_ready, out_res_num, out_res_den,
//                     out_compare_true, out_status
//
// a zero denominator goes from acceptance straight to the output state; any other
// transaction runs up to three shift-add multiply passes, a binary gcd and two
// divides on the shared unit. compare commands use two multiplies only.
// in_ready is low from acceptance until the result is taken.
// reset clears the sequencer; out_valid holds until out_ready.
module rational_arithmetic_unit #(
  parameter int VALUE_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_command,
  input  logic signed [31:0] in_a_num,
  input  logic signed [31:0] in_a_den,
  input  logic signed [31:0] in_b_num,
  input  logic signed [31:0] in_b_den,
  output logic        out_valid,
  input  logic        out_ready,
  output logic signed [31:0] out_res_num,
  output logic [30:0] out_res_den,
  output logic        out_compare_true,
  output logic [1:0]  out_status
);

  typedef enum logic [9:0] {
    S_IDLE = 10'b0000000001,
    S_M1   = 10'b0000000010,
    S_M2   = 10'b0000000100,
    S_M3   = 10'b0000001000,
    S_SUM  = 10'b0000010000,
    S_GCD  = 10'b0000100000,
    S_D1   = 10'b0001000000,
    S_D2   = 10'b0010000000,
    S_CHK  = 10'b0100000000,
    S_OUT  = 10'b1000000000
  } state_t;

  localparam logic [63:0] LIMIT = (64'd1 << (VALUE_WIDTH - 1)) - 64'd1;

  state_t state_r, state_nxt;
  rau_pkg::cmd_t cmd_r;
  logic        an_neg_r, bn_neg_r, ad_neg_r, bd_neg_r;
  logic [63:0] an_r, ad_r, bn_r, bd_r;
  logic [63:0] p1_r, p2_r, p3_r, num_r, gcd_r;
  logic        neg_r, issued_r;
  logic signed [31:0] rnum_r;
  logic [30:0] rden_r;
  logic        cmp_r;
  logic [1:0]  st_r;
  rau_pkg::unit_req_t req;
  logic [63:0] opa, opb, ures;
  logic        udone;

  rau_unit u_unit (
    .clk(clk), .rst_n(rst_n), .req(req), .opa(opa), .opb(opb),
    .done(udone), .res(ures)
  );

  // sign-extend the low VALUE_WIDTH bits into sign and magnitude
  function automatic logic [64:0] unpack(input logic [31:0] raw);
    logic [31:0] v;
    logic        s;
    v = raw << (32 - VALUE_WIDTH);
    s = v[31];
    v = $unsigned($signed(v) >>> (32 - VALUE_WIDTH));
    return {s, 32'd0, s ? 32'd0 - v : v};
  endfunction

  logic [64:0] u_an, u_ad, u_bn, u_bd;
  assign u_an = unpack(in_a_num);
  assign u_ad = unpack(in_a_den);
  assign u_bn = unpack(in_b_num);
  assign u_bd = unpack(in_b_den);

  assign in_ready = (state_r == S_IDLE);
  assign out_valid = (state_r == S_OUT);
  assign out_res_num = rnum_r;
  assign out_res_den = rden_r;
  assign out_compare_true = cmp_r;
  assign out_status = st_r;

  // effective signs
  logic a_neg, b_neg;
  assign a_neg = an_neg_r ^ ad_neg_r;
  assign b_neg = bn_neg_r ^ bd_neg_r;

  // multiply operands per pass: p1 and p2 are the cross terms (p1 the numerator product for mul and div), p3 the den
  always_comb begin
    opa = 64'd0; opb = 64'd0;
    req.op = rau_pkg::OP_NONE;
    req.start = (state_r != S_IDLE) && (state_r != S_OUT) && !issued_r;
    case (state_r)
      S_M1: begin
        req.op = rau_pkg::OP_MUL; opa = an_r;
        opb = (cmd_r == rau_pkg::CMD_MUL) ? bn_r : bd_r;
      end
      S_M2: begin
        req.op = rau_pkg::OP_MUL; opa = bn_r; opb = ad_r;
      end
      S_M3: begin
        req.op = rau_pkg::OP_MUL; opa = ad_r;
        opb = (cmd_r == rau_pkg::CMD_DIV) ? bn_r : bd_r;
      end
      S_GCD: begin req.op = rau_pkg::OP_GCD; opa = num_r; opb = p3_r; end
      S_D1:  begin req.op = rau_pkg::OP_DIV; opa = num_r; opb = gcd_r; end
      S_D2:  begin req.op = rau_pkg::OP_DIV; opa = p3_r; opb = gcd_r; end
      default: req.start = 1'b0;
    endcase
  end

  // signed sum of the cross terms; second term sign per command
  logic        t2_neg, sum_neg;
  logic [63:0] sum_mag;
  always_comb begin
    t2_neg = (cmd_r == rau_pkg::CMD_ADD) ? b_neg : !b_neg;
    if (a_neg == t2_neg) begin
      sum_neg = a_neg; sum_mag = p1_r + p2_r;
    end else if (p1_r >= p2_r) begin
      sum_neg = a_neg; sum_mag = p1_r - p2_r;
    end else begin
      sum_neg = t2_neg; sum_mag = p2_r - p1_r;
    end
  end

  logic zero_err;
  assign zero_err = (u_ad[63:0] == 64'd0) ||
                    (in_command != rau_pkg::CMD_NORM && u_bd[63:0] == 64'd0) ||
                    (in_command == rau_pkg::CMD_DIV && u_bn[63:0] == 64'd0);

  logic num_zero;
  assign num_zero = (cmd_r == rau_pkg::CMD_NORM) ? (an_r == 64'd0) :
                    (cmd_r == rau_pkg::CMD_MUL || cmd_r == rau_pkg::CMD_DIV) ?
                    (p1_r == 64'd0) : (sum_mag == 64'd0);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (in_valid) state_nxt = zero_err ? S_OUT :
                 (in_command == rau_pkg::CMD_NORM) ? S_SUM : S_M1;
      S_M1:   if (udone) state_nxt = (cmd_r == rau_pkg::CMD_MUL ||
                                      cmd_r == rau_pkg::CMD_DIV) ? S_M3 : S_M2;
      S_M2:   if (udone) state_nxt = (cmd_r == rau_pkg::CMD_EQ ||
                                      cmd_r == rau_pkg::CMD_LT ||
                                      cmd_r == rau_pkg::CMD_GT) ? S_SUM : S_M3;
      S_M3:   if (udone) state_nxt = S_SUM;
      S_SUM:  state_nxt = S_GCD;
      S_GCD:  if (udone) state_nxt = S_D1;
      S_D1:   if (udone) state_nxt = S_D2;
      S_D2:   if (udone) state_nxt = S_CHK;
      S_CHK:  state_nxt = S_OUT;
      S_OUT:  if (out_ready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
    // compare and zero-numerator results skip the reduction
    if (state_r == S_SUM && (cmd_r == rau_pkg::CMD_EQ || cmd_r == rau_pkg::CMD_LT ||
        cmd_r == rau_pkg::CMD_GT || num_zero)) state_nxt = S_OUT;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE; issued_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      issued_r <= (state_nxt == state_r) ? (issued_r | req.start) : 1'b0;
    end
    // capture operands
    if (state_r == S_IDLE && in_valid) begin
      cmd_r <= rau_pkg::cmd_t'(in_command);
      an_neg_r <= u_an[64]; an_r <= u_an[63:0];
      ad_neg_r <= u_ad[64]; ad_r <= u_ad[63:0];
      bn_neg_r <= u_bn[64]; bn_r <= u_bn[63:0];
      bd_neg_r <= u_bd[64]; bd_r <= u_bd[63:0];
      rnum_r <= 32'sd0; rden_r <= 31'd1; cmp_r <= 1'b0;
      st_r <= zero_err ? rau_pkg::ST_ZERO : rau_pkg::ST_OK;
    end
    if (udone && state_r == S_M1) p1_r <= ures;
    if (udone && state_r == S_M2) p2_r <= ures;
    if (udone && state_r == S_M3) p3_r <= ures;
    if (state_r == S_SUM) begin
      case (cmd_r)
        rau_pkg::CMD_NORM: begin num_r <= an_r; neg_r <= a_neg; p3_r <= ad_r; end
        rau_pkg::CMD_MUL, rau_pkg::CMD_DIV: begin
          num_r <= p1_r; neg_r <= a_neg ^ b_neg;
        end
        default: begin num_r <= sum_mag; neg_r <= sum_neg; end
      endcase
      case (cmd_r)
        rau_pkg::CMD_EQ: cmp_r <= (sum_mag == 64'd0);
        rau_pkg::CMD_LT: cmp_r <= (sum_mag != 64'd0) && sum_neg;
        rau_pkg::CMD_GT: cmp_r <= (sum_mag != 64'd0) && !sum_neg;
        default: cmp_r <= 1'b0;
      endcase
    end
    if (udone && state_r == S_GCD) gcd_r <= ures;
    if (udone && state_r == S_D1) num_r <= ures;
    if (udone && state_r == S_D2) p3_r <= ures;
    // range check and final packing
    if (state_r == S_CHK) begin
      if (p3_r > LIMIT || num_r > (neg_r ? LIMIT + 64'd1 : LIMIT)) begin
        st_r <= rau_pkg::ST_OVF;
      end else begin
        rnum_r <= neg_r ? 32'd0 - num_r[31:0] : num_r[31:0];
        rden_r <= p3_r[30:0];
      end
    end
  end

  // checks
  a_busy_not_ready: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> !in_ready) else $error("ready while busy");
  a_cmp_only_on_compare: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_compare_true) |-> (out_status == rau_pkg::ST_OK))
    else $error("compare flag with bad status");
  a_err_gives_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != rau_pkg::ST_OK) |->
    (out_res_num == 32'sd0 && out_res_den == 31'd1)) else $error("error result not 0/1");
  a_den_positive: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_res_den != 31'd0)) else $error("zero denominator out");

endmodule

/* verif/tb.sv */
// tb: self-checking testbench for the rational arithmetic unit
// depends on rau_pkg and rational_arithmetic_unit; predicts each result itself
`timescale 1ns / 100ps

module tb;

  localparam int VW = 32;
  localparam longint unsigned CYCLE_LIMIT = 2000000;

  typedef struct {
    logic signed [31:0] res_num;
    logic [30:0]        res_den;
    logic               compare_true;
    rau_pkg::status_t   status;
  } frac_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [2:0] in_command = '0;
  logic signed [31:0] in_a_num = '0, in_a_den = '0, in_b_num = '0, in_b_den = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [31:0] out_res_num;
  logic [30:0] out_res_den;
  logic out_compare_true;
  logic [1:0] out_status;

  frac_result_t expected_results[$];
  int unsigned fail_count = 0;
  int unsigned sent_count = 0;
  int unsigned checked_count = 0;
  longint unsigned cycle_count = 0;
  bit idle_free = 1'b0;

  rational_arithmetic_unit #(.VALUE_WIDTH(VW)) u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_command(in_command),
    .in_a_num(in_a_num), .in_a_den(in_a_den), .in_b_num(in_b_num),
    .in_b_den(in_b_den),
    .out_valid(out_valid), .out_ready(out_ready), .out_res_num(out_res_num),
    .out_res_den(out_res_den), .out_compare_true(out_compare_true),
    .out_status(out_status)
  );

  always #10 clk = ~clk;

  // split a part into sign and magnitude
  function automatic void split_part(input logic [31:0] raw, output bit neg,
                                     output logic [63:0] mag);
    neg = raw[31];
    mag = neg ? (64'd1 << 32) - {32'd0, raw} : {32'd0, raw};
  endfunction

  // signed sum in sign-magnitude form
  function automatic void sm_sum(input bit xn, input logic [63:0] xm, input bit yn,
                                 input logic [63:0] ym, output bit rn,
                                 output logic [63:0] rm);
    if (xn == yn) begin
      rn = xn; rm = xm + ym;
    end else if (xm >= ym) begin
      rn = xn; rm = xm - ym;
    end else begin
      rn = yn; rm = ym - xm;
    end
  endfunction

  // exact reduced fraction result for one command
  function automatic frac_result_t reduce_fraction(rau_pkg::cmd_t cmd, logic [31:0] an_r,
      logic [31:0] ad_r, logic [31:0] bn_r, logic [31:0] bd_r);
    frac_result_t r;
    bit an_s, ad_s, bn_s, bd_s, a_s, b_s, t1_s, t2_s, n_s, d_s;
    logic [63:0] an_m, ad_m, bn_m, bd_m, t1_m, t2_m, n_m, d_m, den, g, x, y, t, lim;
    r.res_num = '0; r.res_den = 31'd1; r.compare_true = 1'b0; r.status = rau_pkg::ST_OK;
    split_part(an_r, an_s, an_m);
    split_part(ad_r, ad_s, ad_m);
    split_part(bn_r, bn_s, bn_m);
    split_part(bd_r, bd_s, bd_m);
    if (ad_m == 0 || (cmd != rau_pkg::CMD_NORM && bd_m == 0) ||
        (cmd == rau_pkg::CMD_DIV && bn_m == 0)) begin
      r.status = rau_pkg::ST_ZERO;
      return r;
    end
    a_s = an_s ^ ad_s;
    b_s = bn_s ^ bd_s;
    t1_s = a_s; t1_m = an_m * bd_m;
    t2_s = !b_s; t2_m = bn_m * ad_m;
    if (cmd inside {rau_pkg::CMD_EQ, rau_pkg::CMD_LT, rau_pkg::CMD_GT}) begin
      sm_sum(t1_s, t1_m, t2_s, t2_m, d_s, d_m);
      case (cmd)
        rau_pkg::CMD_EQ: r.compare_true = (d_m == 0);
        rau_pkg::CMD_LT: r.compare_true = (d_m != 0) && d_s;
        default: r.compare_true = (d_m != 0) && !d_s;
      endcase
      return r;
    end
    case (cmd)
      rau_pkg::CMD_NORM: begin
        n_s = a_s; n_m = an_m; den = ad_m;
      end
      rau_pkg::CMD_ADD: begin
        sm_sum(t1_s, t1_m, b_s, t2_m, n_s, n_m); den = ad_m * bd_m;
      end
      rau_pkg::CMD_SUB: begin
        sm_sum(t1_s, t1_m, t2_s, t2_m, n_s, n_m); den = ad_m * bd_m;
      end
      rau_pkg::CMD_MUL: begin
        n_s = a_s ^ b_s; n_m = an_m * bn_m; den = ad_m * bd_m;
      end
      default: begin
        n_s = a_s ^ b_s; n_m = an_m * bd_m; den = ad_m * bn_m;
      end
    endcase
    if (n_m == 0) return r;
    x = n_m; y = den;
    while (y != 0) begin
      t = x % y; x = y; y = t;
    end
    g = x;
    n_m = n_m / g;
    den = den / g;
    lim = (64'd1 << (VW - 1)) - 64'd1;
    if (den > lim || n_m > (n_s ? lim + 64'd1 : lim)) begin
      r.status = rau_pkg::ST_OVF;
      return r;
    end
    r.res_num = n_s ? 32'(-n_m) : 32'(n_m);
    r.res_den = 31'(den);
    return r;
  endfunction

  function automatic int unsigned draw_gap();
    return idle_free ? 0 : $urandom_range(0, 12);
  endfunction

  // send one transaction and queue its expected result
  task automatic send_fraction_op(rau_pkg::cmd_t cmd, logic [31:0] an, logic [31:0] ad,
                                  logic [31:0] bn, logic [31:0] bd);
    int unsigned gap;
    gap = draw_gap();
    // idle cycles first; with no gap valid stays up for the next transaction
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_command <= cmd;
    in_a_num <= an; in_a_den <= ad; in_b_num <= bn; in_b_den <= bd;
    expected_results.insert(expected_results.size(), reduce_fraction(cmd, an, ad, bn, bd));
    sent_count++;
    do @(posedge clk); while (!in_ready);
  endtask

  // result checker with random backpressure
  initial begin : result_checker
    frac_result_t exp_r;
    int unsigned gap;
    @(posedge rst_n);
    forever begin
      gap = draw_gap();
      if (gap != 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      checked_count++;
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result num=%0d den=%0d", $time, out_res_num, out_res_den);
        fail_count++;
      end else begin
        exp_r = expected_results.pop_front();
        if (out_res_num !== exp_r.res_num) begin
          $display("%0t: res_num expected %0d actual %0d", $time, exp_r.res_num, out_res_num);
          fail_count++;
        end
        if (out_res_den !== exp_r.res_den) begin
          $display("%0t: res_den expected %0d actual %0d", $time, exp_r.res_den, out_res_den);
          fail_count++;
        end
        if (out_compare_true !== exp_r.compare_true) begin
          $display("%0t: compare_true expected %0b actual %0b", $time,
                   exp_r.compare_true, out_compare_true);
          fail_count++;
        end
        if (out_status !== exp_r.status) begin
          $display("%0t: status expected %0d actual %0d", $time, exp_r.status, out_status);
          fail_count++;
        end
      end
    end
  end

  // run guard
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results pending", cycle_count,
               expected_results.size());
      $display("rational_arithmetic_unit regression: fail");
      $finish;
    end
  end

  // extremes and special cases, every command
  task automatic test_directed();
    rau_pkg::cmd_t c;
    send_fraction_op(rau_pkg::CMD_NORM, 32'sd6, -32'sd4, 32'sd0, 32'sd0);
    send_fraction_op(rau_pkg::CMD_NORM, 32'sh80000000, 32'sh80000000, 32'sd0, 32'sd0);
    send_fraction_op(rau_pkg::CMD_NORM, 32'sh80000000, -32'sd1, 32'sd0, 32'sd0);
    send_fraction_op(rau_pkg::CMD_NORM, 32'sd0, 32'sd7, 32'sd0, 32'sd0);
    send_fraction_op(rau_pkg::CMD_NORM, 32'sd5, 32'sd0, 32'sd0, 32'sd0);
    send_fraction_op(rau_pkg::CMD_ADD, 32'sd1, 32'sd2, 32'sd1, 32'sd0);
    send_fraction_op(rau_pkg::CMD_ADD, 32'sh7fffffff, 32'sd1, 32'sh7fffffff, 32'sd1);
    send_fraction_op(rau_pkg::CMD_ADD, 32'sd1, 32'sh7fffffff, 32'sd1, 32'sh7ffffffe);
    send_fraction_op(rau_pkg::CMD_SUB, 32'sd3, 32'sd4, 32'sd3, 32'sd4);
    send_fraction_op(rau_pkg::CMD_SUB, 32'sh80000000, 32'sd1, 32'sd1, 32'sd1);
    send_fraction_op(rau_pkg::CMD_MUL, 32'sh80000000, 32'sh80000000, 32'sh80000000,
                     32'sh7fffffff);
    send_fraction_op(rau_pkg::CMD_MUL, -32'sd2, 32'sd3, 32'sd9, -32'sd4);
    send_fraction_op(rau_pkg::CMD_DIV, 32'sd1, 32'sd2, 32'sd0, 32'sd5);
    send_fraction_op(rau_pkg::CMD_DIV, 32'sd1, 32'sd3, -32'sd2, 32'sd3);
    send_fraction_op(rau_pkg::CMD_DIV, 32'sh7fffffff, 32'sd1, 32'sd1, 32'sh7fffffff);
    for (int i = 5; i < 8; i++) begin
      c = rau_pkg::cmd_t'(i);
      send_fraction_op(c, 32'sd1, 32'sd2, -32'sd2, -32'sd4);
      send_fraction_op(c, 32'sh80000000, 32'sd1, 32'sh7fffffff, 32'sd1);
      send_fraction_op(c, 32'sd1, -32'sd3, 32'sd1, 32'sd3);
    end
    send_fraction_op(rau_pkg::CMD_EQ, 32'sd1, 32'sd0, 32'sd1, 32'sd1);
  endtask

  function automatic logic [31:0] rand_part(bit small_bias);
    case ($urandom_range(0, 5))
      0: return $urandom();
      1: return 32'($signed($urandom_range(0, 40)) - 20);
      2: return small_bias ? 32'($urandom_range(1, 1000)) : $urandom();
      3: return {$urandom_range(0, 1) ? 2'b10 : 2'b01, 30'($urandom())};
      4: return 32'($signed($urandom_range(0, 2000)) - 1000);
      default: return $urandom_range(0, 1) ? 32'h80000000 : 32'h7fffffff;
    endcase
  endfunction

  // random operands across all commands
  task automatic test_random(int unsigned count);
    logic [31:0] ad, bd;
    for (int unsigned i = 0; i < count; i++) begin
      idle_free = ((i / 100) % 4 == 3);
      ad = rand_part(1'b1);
      bd = rand_part(1'b1);
      // mostly valid denominators, a few zeros
      if ($urandom_range(0, 30) == 0) ad = 32'd0;
      else if (ad == 0) ad = 32'd1;
      if ($urandom_range(0, 30) == 0) bd = 32'd0;
      else if (bd == 0) bd = 32'hffffffff;
      send_fraction_op(rau_pkg::cmd_t'($urandom_range(0, 7)), rand_part(1'b0), ad,
                       rand_part(1'b0), bd);
    end
    idle_free = 1'b0;
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random(830);
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (500) @(posedge clk);
    $display("sent %0d transactions over all commands, checked %0d results",
             sent_count, checked_count);
    if (fail_count == 0) begin
      $display("rational_arithmetic_unit regression: pass");
    end else begin
      $display("%0d mismatches", fail_count);
      $display("rational_arithmetic_unit regression: fail");
    end
    $finish;
  end

endmodule
